[sv/gbqa_pkg.sv]
// Package for the gamepad button qualifier with auto-repeat.
// Holds the request/response payload types, configuration types and defaults.
// No dependencies; every other file in this block imports it.
package gbqa_pkg;

   localparam int BUTTONS        = 18;
   localparam int BTN_IDX_BITS   = $clog2(BUTTONS);
   localparam int MAX_SLOTS      = 4;
   localparam int PAD_WORD_BITS  = 16;
   localparam int TRIG_BITS      = 8;
   localparam int LEFT_TRIG_BIT  = 16;
   localparam int RIGHT_TRIG_BIT = 17;

   localparam int DEF_SLOTS      = 4;
   localparam int DEF_TIME_BITS  = 32;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [15:0] RST_REPEAT_DELAY    = 16'd400;
   localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd100;
   localparam logic [7:0]  RST_TRIG_THRESHOLD  = 8'd64;
   localparam logic [15:0] RST_DEAD_RETRY      = 16'd1000;

   typedef enum logic [0:0] {
      OP_FRAME = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REPEAT_DELAY    = 2'd0,
      CSR_REPEAT_INTERVAL = 2'd1,
      CSR_TRIG_THRESHOLD  = 2'd2,
      CSR_DEAD_RETRY      = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [15:0] repeat_delay_ms;
      logic [15:0] repeat_interval_ms;
      logic [7:0]  trigger_threshold;
      logic [15:0] dead_slot_retry_ms;
   } cfg_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] time_ms;
      logic [3:0]  slot_reported;
      logic [63:0] slot_buttons;
      logic [63:0] slot_triggers;
      logic [4:0]  button_index;
   } req_type;

   typedef struct packed {
      logic        connected;
      logic [17:0] down_mask;
      logic [17:0] pressed_mask;
      logic [4:0]  first_pressed;
      logic        repeat_res;
      logic [3:0]  slot_live_mask;
   } rsp_type;

   // Button state as it stands after the request in flight has been applied.
   typedef struct packed {
      logic [BUTTONS-1:0] down;
      logic [BUTTONS-1:0] was_down;
      logic               connected;
      logic [MAX_SLOTS-1:0] live;
   } btn_state_type;

   // Lowest set bit of a button mask, BUTTONS when the mask is empty.
   function automatic logic [4:0] first_set(input logic [BUTTONS-1:0] mask);
      logic [4:0] idx;
      logic       found;
      idx   = 5'(BUTTONS);
      found = 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
         if (mask[i] && !found) begin
            idx   = 5'(i);
            found = 1'b1;
         end
      end
      return idx;
   endfunction

endpackage

[sv/gbqa_csr.sv]
// Configuration registers of the button qualifier.
// Depends on gbqa_pkg for the register index codes and the cfg_type struct.
module gbqa_csr
   import gbqa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_REPEAT_DELAY:    cfg_in.repeat_delay_ms    = csr_wdata;
            CSR_REPEAT_INTERVAL: cfg_in.repeat_interval_ms = csr_wdata;
            CSR_TRIG_THRESHOLD:  cfg_in.trigger_threshold  = csr_wdata[TRIG_BITS-1:0];
            CSR_DEAD_RETRY:      cfg_in.dead_slot_retry_ms = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_delay_ms    <= RST_REPEAT_DELAY;
         cfg_ff.repeat_interval_ms <= RST_REPEAT_INTERVAL;
         cfg_ff.trigger_threshold  <= RST_TRIG_THRESHOLD;
         cfg_ff.dead_slot_retry_ms <= RST_DEAD_RETRY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/gbqa_frame.sv]
// Pad slot polling and the 18-button down mask with its previous-frame copy.
// Depends on gbqa_pkg for payload fields, configuration and btn_state_type.
module gbqa_frame
   import gbqa_pkg::*;
#(
   parameter int SLOTS     = DEF_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_fire,
   input  logic [TIME_BITS-1:0] now,
   input  req_type              req,
   input  cfg_type              cfg,
   output btn_state_type        state_nxt,
   output logic [BUTTONS-1:0]   newly_pressed
);

   logic                 slot_live_ff  [SLOTS];
   logic                 slot_live_in  [SLOTS];
   logic [TIME_BITS-1:0] slot_retry_ff [SLOTS];
   logic [TIME_BITS-1:0] slot_retry_in [SLOTS];
   logic [BUTTONS-1:0]   down_ff, down_in;
   logic [BUTTONS-1:0]   was_down_ff, was_down_in;
   logic                 connected_ff, connected_in;

   logic [BUTTONS-1:0]   frame_down;
   logic                 frame_conn;

   always_comb begin
      logic                 skip;
      logic [TIME_BITS-1:0] since;
      logic [7:0]           lt;
      logic [7:0]           rt;
      frame_down = '0;
      frame_conn = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         slot_live_in[s]  = slot_live_ff[s];
         slot_retry_in[s] = slot_retry_ff[s];
         since = now - slot_retry_ff[s];
         skip  = !slot_live_ff[s] && (since < TIME_BITS'(cfg.dead_slot_retry_ms));
         lt    = req.slot_triggers[s*PAD_WORD_BITS +: TRIG_BITS];
         rt    = req.slot_triggers[s*PAD_WORD_BITS + TRIG_BITS +: TRIG_BITS];
         if (!skip) begin
            if (!req.slot_reported[s]) begin
               slot_live_in[s]  = 1'b0;
               slot_retry_in[s] = now;
            end else begin
               slot_live_in[s] = 1'b1;
               frame_conn      = 1'b1;
               frame_down[PAD_WORD_BITS-1:0] = frame_down[PAD_WORD_BITS-1:0]
                                             | req.slot_buttons[s*PAD_WORD_BITS +: PAD_WORD_BITS];
               if (lt >= cfg.trigger_threshold) frame_down[LEFT_TRIG_BIT]  = 1'b1;
               if (rt >= cfg.trigger_threshold) frame_down[RIGHT_TRIG_BIT] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (frame_fire) begin
         down_in      = frame_down;
         was_down_in  = down_ff;
         connected_in = frame_conn;
      end else begin
         down_in      = down_ff;
         was_down_in  = was_down_ff;
         connected_in = connected_ff;
      end
      newly_pressed = frame_fire ? (frame_down & ~down_ff) : '0;
   end

   always_comb begin
      state_nxt.down      = down_in;
      state_nxt.was_down  = was_down_in;
      state_nxt.connected = connected_in;
      state_nxt.live      = '0;
      for (int s = 0; s < SLOTS; s++) begin
         state_nxt.live[s] = frame_fire ? slot_live_in[s] : slot_live_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff      <= '0;
         was_down_ff  <= '0;
         connected_ff <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            slot_live_ff[s]  <= 1'b0;
            slot_retry_ff[s] <= '0;
         end
      end else begin
         down_ff      <= down_in;
         was_down_ff  <= was_down_in;
         connected_ff <= connected_in;
         if (frame_fire) begin
            for (int s = 0; s < SLOTS; s++) begin
               slot_live_ff[s]  <= slot_live_in[s];
               slot_retry_ff[s] <= slot_retry_in[s];
            end
         end
      end
   end

endmodule

[sv/gbqa_repeat.sv]
// Per-button press times and the typematic repeat decision for one query.
// Depends on gbqa_pkg for configuration and btn_state_type.
module gbqa_repeat
   import gbqa_pkg::*;
#(
   parameter int TIME_BITS = DEF_TIME_BITS
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 query_fire,
   input  logic [TIME_BITS-1:0] now,
   input  logic [4:0]           button_index,
   input  cfg_type              cfg,
   input  btn_state_type        state_nxt,
   input  logic [BUTTONS-1:0]   newly_pressed,
   output logic                 repeat_res
);

   logic [TIME_BITS-1:0]    press_time_ff  [BUTTONS];
   logic [TIME_BITS-1:0]    last_repeat_ff [BUTTONS];
   logic [BUTTONS-1:0]      marked_ff, marked_in;

   logic                    in_range;
   logic [BTN_IDX_BITS-1:0] sel;
   logic                    is_down, was_down, marked;
   logic [TIME_BITS-1:0]    held, since_rep;
   logic                    repeat_due;
   logic                    take_repeat;

   assign in_range = (button_index < 5'(BUTTONS));
   assign sel      = in_range ? button_index[BTN_IDX_BITS-1:0] : '0;
   assign is_down  = in_range && state_nxt.down[sel];
   assign was_down = state_nxt.was_down[sel];
   assign marked   = marked_ff[sel];
   assign held     = now - press_time_ff[sel];
   assign since_rep = now - last_repeat_ff[sel];

   // A held button repeats once the delay has passed, and then no more often
   // than the interval allows.
   assign repeat_due = (held >= TIME_BITS'(cfg.repeat_delay_ms))
                     && (!marked || (since_rep >= TIME_BITS'(cfg.repeat_interval_ms)));

   always_comb begin
      repeat_res  = 1'b0;
      take_repeat = 1'b0;
      if (is_down) begin
         if (!was_down) begin
            repeat_res = 1'b1;
         end else if (repeat_due) begin
            repeat_res  = 1'b1;
            take_repeat = query_fire;
         end
      end
   end

   always_comb begin
      marked_in = marked_ff & ~newly_pressed;
      if (take_repeat) marked_in[sel] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marked_ff <= '0;
      end else begin
         marked_ff <= marked_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < BUTTONS; b++) begin
         if (newly_pressed[b]) press_time_ff[b] <= now;
      end
      if (take_repeat) last_repeat_ff[sel] <= now;
   end

endmodule

[sv/gamepad_button_qualifier_autorepeat.sv]
// Top level of the gamepad button qualifier with typematic auto-repeat.
// Depends on gbqa_pkg, gbqa_csr, gbqa_frame and gbqa_repeat.
//
//   Channel   Direction  Handshake             Payload
//   req_*     in         req_valid/req_stall   req_type (frame update or repeat query)
//   rsp_*     out        rsp_valid/rsp_stall   rsp_type (one response per request)
//   csr_*     in         csr_valid/csr_ready   csr_index, csr_wdata
//
// A request is held in an input register and is applied to the button state
// when the output register can take it, as its response is written there;
// one request can be taken every cycle while the response is not stalled.
// Updating slot and button state as the response is written sets that rate.
// Synchronous reset clears slot state, button masks, repeat marks and valid flags.
// A stalled response holds the input stage, which then stalls new requests.
module gamepad_button_qualifier_autorepeat
   import gbqa_pkg::*;
#(
   parameter int SLOTS     = DEF_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   req_type              req_ff;
   logic                 req_valid_ff, req_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 advance;
   logic                 frame_fire, query_fire;
   logic [TIME_BITS-1:0] now;
   cfg_type              cfg;
   btn_state_type        state_nxt;
   logic [BUTTONS-1:0]   newly_pressed;
   logic [BUTTONS-1:0]   pressed;
   logic                 repeat_res;

   assign advance    = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = req_valid_ff && !advance;
   assign frame_fire = advance && (req_ff.operation == OP_FRAME);
   assign query_fire = advance && (req_ff.operation == OP_QUERY);
   assign now        = req_ff.time_ms[TIME_BITS-1:0];

   gbqa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbqa_frame #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .frame_fire    (frame_fire),
      .now           (now),
      .req           (req_ff),
      .cfg           (cfg),
      .state_nxt     (state_nxt),
      .newly_pressed (newly_pressed)
   );

   gbqa_repeat #(
      .TIME_BITS (TIME_BITS)
   ) u_repeat (
      .clock         (clock),
      .reset         (reset),
      .query_fire    (query_fire),
      .now           (now),
      .button_index  (req_ff.button_index),
      .cfg           (cfg),
      .state_nxt     (state_nxt),
      .newly_pressed (newly_pressed),
      .repeat_res    (repeat_res)
   );

   assign pressed = state_nxt.down & ~state_nxt.was_down;

   always_comb begin
      rsp_in.connected      = state_nxt.connected;
      rsp_in.down_mask      = state_nxt.down;
      rsp_in.pressed_mask   = pressed;
      rsp_in.first_pressed  = first_set(pressed);
      rsp_in.repeat_res     = (req_ff.operation == OP_QUERY) ? repeat_res : 1'b0;
      rsp_in.slot_live_mask = state_nxt.live;
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      if (advance) req_valid_in = 1'b0;
      if (req_valid && !req_stall) req_valid_in = 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) req_ff <= req_payload;
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
